/* hw/rtl/bmp24_pkg.sv */
// bmp24_pkg: word types, status codes, phase codes and header layout constants
// for the 24-bit bmp stream decoder
// no dependencies
package bmp24_pkg;

	typedef enum logic [2:0] {
		ST_PIXEL      = 3'd0,
		ST_BAD_MAGIC  = 3'd1,
		ST_COMPRESSED = 3'd2,
		ST_BAD_DEPTH  = 3'd3,
		ST_SHORT_HDR  = 3'd4,
		ST_TRUNCATED  = 3'd5,
		ST_TOO_LARGE  = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_PIXELS = 2'd1,
		PH_PAD    = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       end_of_file;
	} in_word_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic        last_result;
	} out_word_t;

	localparam logic [5:0]  HDR_LAST   = 6'd53;
	localparam logic [5:0]  OFS_WIDTH  = 6'd18;
	localparam logic [5:0]  OFS_HEIGHT = 6'd22;
	localparam logic [5:0]  OFS_PLANES = 6'd26;
	localparam logic [5:0]  OFS_BITS   = 6'd28;
	localparam logic [5:0]  OFS_COMPR  = 6'd30;
	localparam logic [15:0] BMP_MAGIC  = 16'h4D42;
	localparam logic [31:0] BMP_DEPTH  = 32'd24;

endpackage

/* hw/rtl/bmp24_stream_decoder.sv */
// bmp24_stream_decoder: top level, header parse, pixel assembly and result queue
// depends on bmp24_pkg
//
// Takes one file byte per cycle: the 54-byte header is parsed, then every B,G,R
// triple gives one pixel word with its column and row (row mirrored when the
// flip register is set), row padding is skipped, and header problems, an early
// end of header or an early end of pixel data give one error word. A byte makes
// at most two result words, which go into a four-entry result queue; the byte
// input stalls while that queue holds three or more words, so with the result
// side never stalling a byte is taken every cycle. The end-of-file byte returns
// the decoder to its start so that the next byte begins a new file.
module bmp24_stream_decoder
	import bmp24_pkg::*;
#(
	parameter int MAX_DIM = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      flip_we,
	input  logic      flip_wdata,
	input  logic      file_valid,
	output logic      file_stall,
	input  in_word_t  file_data,
	output logic      pix_valid,
	input  logic      pix_stall,
	output out_word_t pix_data
);

	localparam int CW = $clog2(MAX_DIM + 1);

	logic          flip_q;
	phase_t        phase_q, phase_n;
	logic [5:0]    hpos_q, hpos_n;
	logic [31:0]   width_q, width_n;
	logic [31:0]   height_q, height_n;
	logic [15:0]   planes_q, planes_n;
	logic [15:0]   bits_q, bits_n;
	logic [31:0]   compr_q, compr_n;
	logic [CW-1:0] col_q, col_n;
	logic [CW-1:0] row_q, row_n;
	logic [1:0]    bip_q, bip_n;
	logic [1:0]    pad_q, pad_n;
	logic [15:0]   hold_q, hold_n;

	out_word_t     res0, res1;
	logic [1:0]    nres;

	out_word_t     queue_q [4];
	logic [1:0]    wr_q, rd_q;
	logic [2:0]    cnt_q;
	logic          accept, pop;

	assign file_stall = (cnt_q > 3'd2);
	assign accept     = file_valid && !file_stall;
	assign pix_valid  = (cnt_q != 3'd0);
	assign pop        = pix_valid && !pix_stall;
	assign pix_data   = queue_q[rd_q];

	always_comb begin
		logic [7:0]    b;
		logic [1:0]    lane;
		logic [31:0]   depth;
		status_t       err;
		logic          err_hit;
		logic [CW-1:0] col_inc;
		logic [CW-1:0] row_inc;
		logic          last;
		logic [31:0]   y_full;
		logic [31:0]   col_ext;
		b        = file_data.file_byte;
		lane     = 2'd0;
		depth    = 32'(planes_q) * 32'(bits_q);
		err      = ST_PIXEL;
		err_hit  = 1'b0;
		col_inc  = col_q + 1'b1;
		row_inc  = row_q + 1'b1;
		last     = (col_inc == width_q[CW-1:0]) && (row_inc == height_q[CW-1:0]);
		y_full   = flip_q ? (height_q - 32'd1 - 32'(row_q)) : 32'(row_q);
		col_ext  = 32'(col_q);
		phase_n  = phase_q;
		hpos_n   = hpos_q;
		width_n  = width_q;
		height_n = height_q;
		planes_n = planes_q;
		bits_n   = bits_q;
		compr_n  = compr_q;
		col_n    = col_q;
		row_n    = row_q;
		bip_n    = bip_q;
		pad_n    = pad_q;
		hold_n   = hold_q;
		res0     = '0;
		res1     = '0;
		nres     = 2'd0;

		case (phase_q)
			PH_HEADER: begin
				if (hpos_q == 6'd0) begin
					hold_n[7:0] = b;
				end else if (hpos_q == 6'd1) begin
					hold_n[15:8] = b;
				end else if (hpos_q >= OFS_WIDTH && hpos_q < OFS_HEIGHT) begin
					lane = 2'(hpos_q - OFS_WIDTH);
					width_n[{lane, 3'b000} +: 8] = b;
				end else if (hpos_q >= OFS_HEIGHT && hpos_q < OFS_PLANES) begin
					lane = 2'(hpos_q - OFS_HEIGHT);
					height_n[{lane, 3'b000} +: 8] = b;
				end else if (hpos_q >= OFS_PLANES && hpos_q < OFS_BITS) begin
					lane = 2'(hpos_q - OFS_PLANES);
					planes_n[{lane[0], 3'b000} +: 8] = b;
				end else if (hpos_q >= OFS_BITS && hpos_q < OFS_COMPR) begin
					lane = 2'(hpos_q - OFS_BITS);
					bits_n[{lane[0], 3'b000} +: 8] = b;
				end else if (hpos_q >= OFS_COMPR && hpos_q < OFS_COMPR + 6'd4) begin
					lane = 2'(hpos_q - OFS_COMPR);
					compr_n[{lane, 3'b000} +: 8] = b;
				end
				if (hpos_q >= HDR_LAST) begin
					err_hit = 1'b1;
					if (hold_q != BMP_MAGIC) begin
						err = ST_BAD_MAGIC;
					end else if (compr_q != 32'd0) begin
						err = ST_COMPRESSED;
					end else if (depth != BMP_DEPTH) begin
						err = ST_BAD_DEPTH;
					end else if (width_q > 32'(MAX_DIM) || height_q > 32'(MAX_DIM)) begin
						err = ST_TOO_LARGE;
					end else begin
						err_hit = 1'b0;
					end
					if (err_hit) begin
						res0.status      = err;
						res0.last_result = 1'b1;
						nres             = 2'd1;
						phase_n          = PH_DONE;
					end else if (width_q == 32'd0 || height_q == 32'd0) begin
						phase_n = PH_DONE;
					end else begin
						phase_n = PH_PIXELS;
						col_n   = '0;
						row_n   = '0;
						bip_n   = 2'd0;
						hold_n  = 16'd0;
					end
				end else begin
					hpos_n = hpos_q + 6'd1;
				end
			end
			PH_PIXELS: begin
				case (bip_q)
					2'd0: begin
						hold_n[7:0] = b;
						bip_n       = 2'd1;
					end
					2'd1: begin
						hold_n[15:8] = b;
						bip_n        = 2'd2;
					end
					default: begin
						res0.status      = ST_PIXEL;
						res0.red         = b;
						res0.green       = hold_q[15:8];
						res0.blue        = hold_q[7:0];
						res0.pixel_x     = col_ext[11:0];
						res0.pixel_y     = y_full[11:0];
						res0.last_result = last;
						nres             = 2'd1;
						bip_n            = 2'd0;
						if (col_inc >= width_q[CW-1:0]) begin
							col_n = '0;
							if (last) begin
								phase_n = PH_DONE;
							end else begin
								row_n = row_inc;
								pad_n = width_q[1:0];
								if (width_q[1:0] != 2'd0) begin
									phase_n = PH_PAD;
								end
							end
						end else begin
							col_n = col_inc;
						end
					end
				endcase
			end
			PH_PAD: begin
				pad_n = pad_q - 2'd1;
				if (pad_n == 2'd0) begin
					phase_n = PH_PIXELS;
				end
			end
			default: begin
			end
		endcase

		if (file_data.end_of_file) begin
			if (phase_n != PH_DONE) begin
				if (nres == 2'd0) begin
					res0.status      = (phase_n == PH_HEADER) ? ST_SHORT_HDR : ST_TRUNCATED;
					res0.last_result = 1'b1;
				end else begin
					res1.status      = (phase_n == PH_HEADER) ? ST_SHORT_HDR : ST_TRUNCATED;
					res1.last_result = 1'b1;
				end
				nres = nres + 2'd1;
			end
			phase_n  = PH_HEADER;
			hpos_n   = 6'd0;
			width_n  = 32'd0;
			height_n = 32'd0;
			planes_n = 16'd0;
			bits_n   = 16'd0;
			compr_n  = 32'd0;
			col_n    = '0;
			row_n    = '0;
			bip_n    = 2'd0;
			pad_n    = 2'd0;
			hold_n   = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_q   <= 1'b0;
			phase_q  <= PH_HEADER;
			hpos_q   <= 6'd0;
			width_q  <= 32'd0;
			height_q <= 32'd0;
			planes_q <= 16'd0;
			bits_q   <= 16'd0;
			compr_q  <= 32'd0;
			col_q    <= '0;
			row_q    <= '0;
			bip_q    <= 2'd0;
			pad_q    <= 2'd0;
			hold_q   <= 16'd0;
		end else begin
			if (flip_we) begin
				flip_q <= flip_wdata;
			end
			if (accept) begin
				phase_q  <= phase_n;
				hpos_q   <= hpos_n;
				width_q  <= width_n;
				height_q <= height_n;
				planes_q <= planes_n;
				bits_q   <= bits_n;
				compr_q  <= compr_n;
				col_q    <= col_n;
				row_q    <= row_n;
				bip_q    <= bip_n;
				pad_q    <= pad_n;
				hold_q   <= hold_n;
			end
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (accept && nres != 2'd0) begin
			queue_q[wr_q] <= res0;
			if (nres == 2'd2) begin
				queue_q[wr_q + 2'd1] <= res1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (accept) begin
				wr_q <= wr_q + nres;
			end
			if (pop) begin
				rd_q <= rd_q + 2'd1;
			end
			cnt_q <= cnt_q + (accept ? 3'(nres) : 3'd0) - (pop ? 3'd1 : 3'd0);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("result queue overflow");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_data.status != ST_PIXEL |-> pix_data.last_result)
		else $error("error word without last flag");

	a_pix_dims: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PIXELS |-> width_q != 32'd0 && height_q != 32'd0)
		else $error("pixel phase with empty image");

	a_pad_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAD |-> pad_q != 2'd0)
		else $error("padding phase with nothing to skip");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PIXELS |-> 32'(col_q) < width_q && 32'(row_q) < height_q)
		else $error("pixel position outside image");

endmodule

/* tb/bmp24_stream_decoder_tb.sv */
// bmp24_stream_decoder_tb: self-checking bench for the 24-bit bmp stream decoder
// drives bmp files, whole or cut short, a word at a time and checks every result word against a
// behavioral decoder kept inside the bench; depends on bmp24_pkg and bmp24_stream_decoder
`timescale 1ns / 1ps

module bmp24_stream_decoder_tb;
	import bmp24_pkg::*;

	localparam int unsigned DIM_LIMIT = 4096;
	localparam int LEN_FULL = -1;
	localparam int NUM_DIR = 21;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic [15:0] magic;
		logic [31:0] width;
		logic [31:0] height;
		logic [15:0] planes;
		logic [15:0] bpp;
		logic [31:0] compr;
		int          len;
		bit          flip;
		bit          typed;
		status_t     st;
	} dir_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      flip_we = 1'b0;
	logic      flip_wdata = 1'b0;
	logic      file_valid = 1'b0;
	logic      file_stall;
	in_word_t  file_data = '0;
	logic      pix_valid;
	logic      pix_stall = 1'b0;
	out_word_t pix_data;

	bmp24_stream_decoder #(
		.MAX_DIM(DIM_LIMIT)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.flip_we    (flip_we),
		.flip_wdata (flip_wdata),
		.file_valid (file_valid),
		.file_stall (file_stall),
		.file_data  (file_data),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pix_data   (pix_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// decoder model state
	bit          flip_q;
	int unsigned hdr_pos;
	phase_t      dec_phase;
	int unsigned img_w;
	int unsigned img_h;
	int unsigned planes_f;
	int unsigned bits_f;
	int unsigned compr_f;
	int unsigned col_n;
	int unsigned row_n;
	int unsigned tri_n;
	int unsigned pad_n;
	int unsigned bg_hold;

	out_word_t want_words[$];
	in_word_t  file_q[$];
	dir_row_t  dir_rows[NUM_DIR];
	int        errors = 0;
	int        bytes_sent = 0;
	int        tx_idle_pct = 0;
	int        rx_idle_pct = 0;
	int        hold_ticket = 0;

	task automatic report(string what);
		if (errors < 50)
			$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	function automatic void clear_decoder();
		hdr_pos = 0;
		dec_phase = PH_HEADER;
		img_w = 0;
		img_h = 0;
		planes_f = 0;
		bits_f = 0;
		compr_f = 0;
		col_n = 0;
		row_n = 0;
		tri_n = 0;
		pad_n = 0;
		bg_hold = 0;
	endfunction

	function automatic out_word_t err_word(status_t st);
		out_word_t r;
		r = '0;
		r.status = st;
		r.last_result = 1'b1;
		return r;
	endfunction

	function automatic void push_want(out_word_t r, bit typed, status_t typed_st);
		want_words.push_back(typed ? err_word(typed_st) : r);
	endfunction

	function automatic void decode_byte(logic [7:0] b, logic e, bit typed, status_t typed_st);
		int unsigned v;
		int unsigned p;
		int unsigned y;
		bit          is_last;
		bit          bad;
		status_t     st;
		out_word_t   r;
		v = b;
		p = hdr_pos;
		st = ST_PIXEL;
		bad = 1'b0;
		case (dec_phase)
			PH_HEADER: begin
				if (p == 0) bg_hold = v;
				else if (p == 1) bg_hold |= v << 8;
				else if (p >= OFS_WIDTH && p < OFS_WIDTH + 4)
					img_w |= v << (8 * (p - OFS_WIDTH));
				else if (p >= OFS_HEIGHT && p < OFS_HEIGHT + 4)
					img_h |= v << (8 * (p - OFS_HEIGHT));
				else if (p >= OFS_PLANES && p < OFS_PLANES + 2)
					planes_f |= v << (8 * (p - OFS_PLANES));
				else if (p >= OFS_BITS && p < OFS_BITS + 2)
					bits_f |= v << (8 * (p - OFS_BITS));
				else if (p >= OFS_COMPR && p < OFS_COMPR + 4)
					compr_f |= v << (8 * (p - OFS_COMPR));
				if (p >= HDR_LAST) begin
					bad = 1'b1;
					if (bg_hold != BMP_MAGIC) st = ST_BAD_MAGIC;
					else if (compr_f != 0) st = ST_COMPRESSED;
					else if (planes_f * bits_f != BMP_DEPTH) st = ST_BAD_DEPTH;
					else if (img_w > DIM_LIMIT || img_h > DIM_LIMIT) st = ST_TOO_LARGE;
					else bad = 1'b0;
					if (bad) begin
						push_want(err_word(st), typed, typed_st);
						dec_phase = PH_DONE;
					end else if (img_w == 0 || img_h == 0) begin
						dec_phase = PH_DONE;
					end else begin
						dec_phase = PH_PIXELS;
						col_n = 0;
						row_n = 0;
						tri_n = 0;
						bg_hold = 0;
					end
				end else begin
					hdr_pos = (p + 1) & 63;
				end
			end
			PH_PIXELS: begin
				if (tri_n == 0) begin
					bg_hold = v;
					tri_n = 1;
				end else if (tri_n == 1) begin
					bg_hold |= v << 8;
					tri_n = 2;
				end else begin
					y = flip_q ? img_h - 1 - row_n : row_n;
					is_last = (col_n + 1 == img_w) && (row_n + 1 == img_h);
					r.status = ST_PIXEL;
					r.red = b;
					r.green = bg_hold[15:8];
					r.blue = bg_hold[7:0];
					r.pixel_x = col_n[11:0];
					r.pixel_y = y[11:0];
					r.last_result = is_last;
					push_want(r, typed, typed_st);
					tri_n = 0;
					col_n++;
					if (col_n >= img_w) begin
						col_n = 0;
						if (is_last) begin
							dec_phase = PH_DONE;
						end else begin
							row_n++;
							pad_n = img_w & 3;
							if (pad_n != 0) dec_phase = PH_PAD;
						end
					end
				end
			end
			PH_PAD: begin
				pad_n = (pad_n - 1) & 3;
				if (pad_n == 0) dec_phase = PH_PIXELS;
			end
			default: ;
		endcase
		if (e) begin
			if (dec_phase == PH_HEADER)
				push_want(err_word(ST_SHORT_HDR), typed, typed_st);
			else if (dec_phase == PH_PIXELS || dec_phase == PH_PAD)
				push_want(err_word(ST_TRUNCATED), typed, typed_st);
			clear_decoder();
		end
	endfunction

	task automatic check_field(string name, logic [11:0] got, logic [11:0] want);
		if (got !== want)
			report($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task automatic check_word(out_word_t got);
		out_word_t want;
		if (want_words.size() == 0) begin
			report($sformatf("unexpected result word %h", got));
			return;
		end
		want = want_words.pop_front();
		check_field("status", 12'(got.status), 12'(want.status));
		check_field("red", 12'(got.red), 12'(want.red));
		check_field("green", 12'(got.green), 12'(want.green));
		check_field("blue", 12'(got.blue), 12'(want.blue));
		check_field("pixel_x", got.pixel_x, want.pixel_x);
		check_field("pixel_y", got.pixel_y, want.pixel_y);
		check_field("last_result", 12'(got.last_result), 12'(want.last_result));
	endtask

	initial begin : rx_side
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pix_valid && !pix_stall) check_word(pix_data);
			if (hold_ticket != hold_seen) begin
				hold_seen = hold_ticket;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pix_stall <= 1'b1;
			end else begin
				pix_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	function automatic int pix_len(int unsigned w, int unsigned h);
		return int'(h * w * 3 + (h - 1) * (w % 4));
	endfunction

	task automatic build_header(logic [15:0] magic, logic [31:0] w, logic [31:0] h,
			logic [15:0] pl, logic [15:0] bt, logic [31:0] cm);
		in_word_t wd;
		file_q.delete();
		for (int i = 0; i < 54; i++) begin
			wd.end_of_file = 1'b0;
			if (i < 2) wd.file_byte = magic[8 * i +: 8];
			else if (i >= 18 && i < 22) wd.file_byte = w[8 * (i - 18) +: 8];
			else if (i >= 22 && i < 26) wd.file_byte = h[8 * (i - 22) +: 8];
			else if (i >= 26 && i < 28) wd.file_byte = pl[8 * (i - 26) +: 8];
			else if (i >= 28 && i < 30) wd.file_byte = bt[8 * (i - 28) +: 8];
			else if (i >= 30 && i < 34) wd.file_byte = cm[8 * (i - 30) +: 8];
			else wd.file_byte = 8'($urandom_range(255));
			file_q.push_back(wd);
		end
	endtask

	task automatic add_pixels(int n);
		in_word_t wd;
		wd.end_of_file = 1'b0;
		repeat (n) begin
			wd.file_byte = 8'($urandom_range(255));
			file_q.push_back(wd);
		end
	endtask

	task automatic trim_file(int n);
		while (file_q.size() > n) void'(file_q.pop_back());
	endtask

	task automatic send_words(bit typed, status_t st);
		foreach (file_q[i]) begin
			while ($urandom_range(99) < tx_idle_pct) begin
				file_valid <= 1'b0;
				@(posedge clk);
			end
			file_valid <= 1'b1;
			file_data <= file_q[i];
			@(posedge clk);
			while (file_stall) @(posedge clk);
			decode_byte(file_q[i].file_byte, file_q[i].end_of_file, typed, st);
			bytes_sent++;
		end
	endtask

	task automatic wait_drained();
		file_valid <= 1'b0;
		do @(posedge clk); while (want_words.size() != 0);
	endtask

	task automatic set_flip(bit v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		flip_we <= 1'b1;
		flip_wdata <= v;
		@(posedge clk);
		flip_we <= 1'b0;
		flip_q = v;
	endtask

	task automatic random_file();
		int unsigned w;
		int unsigned h;
		int unsigned kind;
		int          n;
		logic [15:0] magic;
		logic [15:0] pl;
		logic [15:0] bt;
		logic [31:0] cm;
		in_word_t    wd;
		kind = $urandom_range(99);
		w = $urandom_range(1, 6);
		h = $urandom_range(1, 3);
		if ($urandom_range(19) == 0) w = $urandom_range(7, 40);
		magic = BMP_MAGIC;
		cm = '0;
		case ($urandom_range(9))
			0: begin pl = 16'd2; bt = 16'd12; end
			1: begin pl = 16'd3; bt = 16'd8; end
			2: begin pl = 16'd24; bt = 16'd1; end
			default: begin pl = 16'd1; bt = 16'd24; end
		endcase
		if (kind >= 70 && kind < 80) begin
			case ($urandom_range(3))
				0: magic ^= 16'(1 << $urandom_range(15));
				1: begin
					cm = $urandom;
					if (cm == 0) cm = 32'd1;
				end
				2: begin
					bt = 16'($urandom_range(65535));
					if (32'(pl) * 32'(bt) == BMP_DEPTH) bt++;
				end
				default: begin
					if ($urandom_range(1)) w = DIM_LIMIT + 1 + $urandom_range(100000);
					else h = $urandom_range(1) ? 32'hFFFF_FFFF : DIM_LIMIT + 1;
				end
			endcase
		end
		if (kind >= 88 && kind < 94) begin
			if ($urandom_range(1)) w = 0;
			else h = 0;
		end
		build_header(magic, w, h, pl, bt, cm);
		if (kind < 60) begin
			n = pix_len(w, h);
			if ($urandom_range(3) == 0) n += (w % 4) + $urandom_range(3);
			add_pixels(n);
		end else if (kind < 70) begin
			add_pixels($urandom_range(0, pix_len(w, h) - 1));
		end else if (kind < 80 || (kind >= 88 && kind < 94)) begin
			add_pixels($urandom_range(8));
		end else if (kind < 88) begin
			trim_file($urandom_range(1, 53));
		end else begin
			// noise, with end-of-file marks scattered through it
			file_q.delete();
			repeat ($urandom_range(1, 30)) begin
				wd.file_byte = 8'($urandom_range(255));
				wd.end_of_file = ($urandom_range(7) == 0);
				file_q.push_back(wd);
			end
		end
		file_q[$].end_of_file = 1'b1;
		send_words(1'b0, ST_PIXEL);
	endtask

	task automatic run_random(int target);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < target) random_file();
	endtask

	initial begin : main_flow
		int n;
		flip_q = 1'b0;
		clear_decoder();
		dir_rows = '{
			'{BMP_MAGIC, 1, 1, 1, 24, 0, 1, 0, 1, ST_SHORT_HDR},
			'{BMP_MAGIC, 1, 1, 1, 24, 0, 53, 0, 1, ST_SHORT_HDR},
			'{BMP_MAGIC, 1, 1, 1, 24, 0, LEN_FULL, 0, 0, ST_PIXEL},
			'{BMP_MAGIC, 3, 2, 1, 24, 0, LEN_FULL, 0, 0, ST_PIXEL},
			'{BMP_MAGIC, 5, 3, 3, 8, 0, LEN_FULL, 1, 0, ST_PIXEL},
			'{BMP_MAGIC, 2, 1, 24, 1, 0, 70, 1, 0, ST_PIXEL},
			'{16'h4E42, 1, 1, 1, 24, 0, 60, 0, 1, ST_BAD_MAGIC},
			'{~BMP_MAGIC, 1, 1, 1, 24, 0, 60, 0, 1, ST_BAD_MAGIC},
			'{BMP_MAGIC, 1, 1, 1, 24, 32'hFFFF_FFFF, 60, 0, 1, ST_COMPRESSED},
			'{BMP_MAGIC, 1, 1, 1, 32, 0, 60, 0, 1, ST_BAD_DEPTH},
			'{BMP_MAGIC, 1, 1, 0, 24, 0, 60, 0, 1, ST_BAD_DEPTH},
			'{BMP_MAGIC, 1, 1, 16'hFFFF, 16'hFFFF, 0, 60, 0, 1, ST_BAD_DEPTH},
			'{BMP_MAGIC, 4097, 1, 1, 24, 0, 60, 0, 1, ST_TOO_LARGE},
			'{BMP_MAGIC, 1, 32'hFFFF_FFFF, 1, 24, 0, 60, 0, 1, ST_TOO_LARGE},
			'{BMP_MAGIC, 0, 5, 1, 24, 0, 60, 0, 0, ST_PIXEL},
			'{BMP_MAGIC, 2, 2, 1, 24, 0, 54, 0, 1, ST_TRUNCATED},
			'{BMP_MAGIC, 4096, 4096, 1, 24, 0, 54, 0, 1, ST_TRUNCATED},
			'{BMP_MAGIC, 2, 3, 1, 24, 0, 61, 1, 0, ST_PIXEL},
			'{BMP_MAGIC, 2, 2, 1, 24, 0, 57, 0, 0, ST_PIXEL},
			'{BMP_MAGIC, 4096, 1, 1, 24, 0, 60, 0, 0, ST_PIXEL},
			'{BMP_MAGIC, 1, 4096, 1, 24, 0, 60, 1, 0, ST_PIXEL}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_flip(1'b0);

		tx_idle_pct = 22;
		rx_idle_pct = 54;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].flip != flip_q) set_flip(dir_rows[i].flip);
			build_header(dir_rows[i].magic, dir_rows[i].width, dir_rows[i].height,
				dir_rows[i].planes, dir_rows[i].bpp, dir_rows[i].compr);
			n = (dir_rows[i].len == LEN_FULL) ?
				54 + pix_len(dir_rows[i].width, dir_rows[i].height) : dir_rows[i].len;
			if (n > 54) add_pixels(n - 54);
			else trim_file(n);
			file_q[$].end_of_file = 1'b1;
			send_words(dir_rows[i].typed, dir_rows[i].st);
		end

		set_flip(1'($urandom_range(1)));
		run_random(100);
		wait_drained();
		run_random(100);

		set_flip(1'($urandom_range(1)));
		tx_idle_pct = 54;
		rx_idle_pct = 22;
		run_random(150);

		set_flip(1'($urandom_range(1)));
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		// receiver holds off while a larger image keeps coming
		hold_ticket++;
		build_header(BMP_MAGIC, 8, 3, 1, 24, 0);
		add_pixels(pix_len(8, 3));
		file_q[$].end_of_file = 1'b1;
		send_words(1'b0, ST_PIXEL);
		run_random(150);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
